### src/assert_macros.svh
// Assertion macros shared by the chunked body decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk_i, off while rst_ni is low.
`define CTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check on a named clock and active-low reset.
`define CTD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

### src/ctd_pkg.sv
// Package for the chunked body decoder: phase and result kind codes,
// character constants, hex digit decode and the result struct. No dependencies.
package ctd_pkg;

  // Default width of the chunk size accumulator
  localparam int unsigned SizeBitsDefault = 32;

  // Characters seen on the wire
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] HexLetter = 8'd10;

  // Decoder phase, one-hot
  typedef enum logic [6:0] {
    PhSize   = 7'b000_0001,
    PhSizeCr = 7'b000_0010,
    PhData   = 7'b000_0100,
    PhDataCr = 7'b000_1000,
    PhDataLf = 7'b001_0000,
    PhDone   = 7'b010_0000,
    PhError  = 7'b100_0000
  } phase_e;

  // Kind of a result word
  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindDone    = 2'd1,
    KindBadSize = 2'd2,
    KindNoCrLf  = 2'd3
  } kind_e;

  // One result word from the decode step
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    kind_e      kind;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Hex digit value of a byte, either case
  function automatic hex_t hex_decode(logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (b >= CharZero && b <= CharNine) begin
      h.val = 4'(b - CharZero);
    end else if (b >= CharLowA && b <= CharLowF) begin
      h.val = 4'(b - CharLowA + HexLetter);
    end else if (b >= CharUpA && b <= CharUpF) begin
      h.val = 4'(b - CharUpA + HexLetter);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### src/ctd_step.sv
// Combinational decode of one body byte: next phase, size count, digit
// count and the result word. Depends on ctd_pkg.
module ctd_step #(
  parameter int unsigned SIZE_BITS = ctd_pkg::SizeBitsDefault,
  parameter int unsigned DigitW    = $clog2(SIZE_BITS / 4 + 1)
) (
  input  ctd_pkg::phase_e       phase_i,
  input  logic [SIZE_BITS-1:0]  count_i,
  input  logic [DigitW-1:0]     digits_i,
  input  logic [7:0]            byte_i,
  output ctd_pkg::phase_e       phase_o,
  output logic [SIZE_BITS-1:0]  count_o,
  output logic [DigitW-1:0]     digits_o,
  output ctd_pkg::result_t      res_o
);

  localparam logic [DigitW-1:0]    MaxDigits = DigitW'(SIZE_BITS / 4);
  localparam logic [SIZE_BITS-1:0] CountOne  = SIZE_BITS'(1);

  ctd_pkg::hex_t hex;

  assign hex = ctd_pkg::hex_decode(byte_i);

  // Phase transitions and result selection
  always_comb begin
    phase_o        = phase_i;
    count_o        = count_i;
    digits_o       = digits_i;
    res_o.valid    = 1'b0;
    res_o.out_byte = 8'h00;
    res_o.kind     = ctd_pkg::KindPayload;
    unique case (phase_i)
      ctd_pkg::PhSize: begin
        if (hex.ok) begin
          if (digits_i >= MaxDigits) begin
            phase_o     = ctd_pkg::PhError;
            res_o.valid = 1'b1;
            res_o.kind  = ctd_pkg::KindBadSize;
          end else begin
            count_o  = {count_i[SIZE_BITS-5:0], hex.val};
            digits_o = digits_i + DigitW'(1);
          end
        end else if (byte_i == ctd_pkg::CharCr) begin
          phase_o = ctd_pkg::PhSizeCr;
        end else begin
          phase_o     = ctd_pkg::PhError;
          res_o.valid = 1'b1;
          res_o.kind  = ctd_pkg::KindBadSize;
        end
      end
      ctd_pkg::PhSizeCr: begin
        if (byte_i != ctd_pkg::CharLf) begin
          phase_o     = ctd_pkg::PhError;
          res_o.valid = 1'b1;
          res_o.kind  = ctd_pkg::KindBadSize;
        end else begin
          digits_o = '0;
          if (count_i == '0) begin
            phase_o     = ctd_pkg::PhDone;
            res_o.valid = 1'b1;
            res_o.kind  = ctd_pkg::KindDone;
          end else begin
            phase_o = ctd_pkg::PhData;
          end
        end
      end
      ctd_pkg::PhData: begin
        count_o        = count_i - CountOne;
        res_o.valid    = 1'b1;
        res_o.out_byte = byte_i;
        if (count_i == CountOne) begin
          phase_o = ctd_pkg::PhDataCr;
        end
      end
      ctd_pkg::PhDataCr: begin
        if (byte_i != ctd_pkg::CharCr) begin
          phase_o     = ctd_pkg::PhError;
          res_o.valid = 1'b1;
          res_o.kind  = ctd_pkg::KindNoCrLf;
        end else begin
          phase_o = ctd_pkg::PhDataLf;
        end
      end
      ctd_pkg::PhDataLf: begin
        if (byte_i != ctd_pkg::CharLf) begin
          phase_o     = ctd_pkg::PhError;
          res_o.valid = 1'b1;
          res_o.kind  = ctd_pkg::KindNoCrLf;
        end else begin
          phase_o  = ctd_pkg::PhSize;
          count_o  = '0;
          digits_o = '0;
        end
      end
      // done and error swallow every byte
      default: begin
        phase_o = phase_i;
      end
    endcase
  end

endmodule

### src/chunked_transfer_decoder.sv
// Top level of the chunked body decoder: input word register, decode step,
// result register. Depends on ctd_pkg, ctd_step and assert_macros.svh.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_ready_o   data_byte_i[7:0]
//   out      out  out_valid_o/out_ready_i out_byte_o[7:0], kind_o[1:0]
//
// One word per cycle while out_ready_i is high; a word is accepted into the
// input register and decoded from there into the result register, where
// its result is offered. Words that give no result still take their slot
// in the input register.
// Reset puts the decoder at the start of a size line with empty registers.
// A stalled result holds the input register, and in_ready_o is low while
// both registers are full and out_ready_i is low.
`include "assert_macros.svh"

module chunked_transfer_decoder #(
  parameter int unsigned SIZE_BITS = ctd_pkg::SizeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o
);

  localparam int unsigned DigitW = $clog2(SIZE_BITS / 4 + 1);

  logic                 s1_valid_q, s1_valid_d;
  logic [7:0]           s1_byte_q;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q;
  ctd_pkg::kind_e       out_kind_q;
  ctd_pkg::phase_e      phase_q, phase_d;
  logic [SIZE_BITS-1:0] count_q, count_d;
  logic [DigitW-1:0]    digits_q, digits_d;
  ctd_pkg::result_t     res;
  logic                 out_free;
  logic                 s1_adv;
  logic                 in_acc;

  // Handshake: the input word moves on whenever the result slot can take it
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode step
  ctd_step #(
    .SIZE_BITS (SIZE_BITS),
    .DigitW    (DigitW)
  ) u_step (
    .phase_i  (phase_q),
    .count_i  (count_q),
    .digits_i (digits_q),
    .byte_i   (s1_byte_q),
    .phase_o  (phase_d),
    .count_o  (count_d),
    .digits_o (digits_d),
    .res_o    (res)
  );

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv ? res.valid : (out_valid_q && !out_ready_i);

  // Control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= ctd_pkg::PhSize;
      count_q     <= '0;
      digits_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        digits_q <= digits_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
    end
    if (s1_adv && res.valid) begin
      out_byte_q <= res.out_byte;
      out_kind_q <= res.kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = out_kind_q;

  // Checks
  `CTD_ASSERT(a_done_sticky,
    (phase_q == ctd_pkg::PhDone) |=> (phase_q == ctd_pkg::PhDone),
    "done phase left before reset")
  `CTD_ASSERT(a_error_sticky,
    (phase_q == ctd_pkg::PhError) |=> (phase_q == ctd_pkg::PhError),
    "error phase left before reset")
  `CTD_ASSERT(a_data_nonzero,
    (phase_q == ctd_pkg::PhData) |-> (count_q != '0),
    "payload phase with zero count")
  `CTD_ASSERT(a_payload_emits,
    (s1_adv && phase_q == ctd_pkg::PhData) |=> out_valid_q,
    "payload word gave no result")
  `CTD_ASSERT(a_stall_full,
    !in_ready_o |-> (s1_valid_q && out_valid_q),
    "input stalled with a free register")

endmodule

### tb/sv/tb_chunked_transfer_decoder.sv
// Self-checking testbench for chunked_transfer_decoder: drives a chunked body
// word by word and checks each result word against a cycle-free predictor.
// Depends on ctd_pkg and the decoder RTL only.
module tb_chunked_transfer_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SizeBits  = ctd_pkg::SizeBitsDefault;
  localparam int unsigned MaxDigits = SizeBits / 4;
  localparam int unsigned BodyWords = 1850;
  localparam int unsigned QuietMax  = 1000;
  localparam int unsigned HoldLen   = 80;
  localparam int unsigned HoldAt    = 1300;
  localparam int unsigned DrainLen  = 8;

  // One decoded result word
  typedef struct packed {
    logic [7:0]     out_byte;
    ctd_pkg::kind_e kind;
  } dec_word_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;

  logic [7:0] body_q[$];
  dec_word_t  expected_words[$];
  int         words_in = 0;
  int         errors   = 0;
  int         quiet    = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // Predictor state
  ctd_pkg::phase_e dec_phase  = ctd_pkg::PhSize;
  logic [31:0]     chunk_left = '0;
  logic [3:0]      digits     = '0;

  chunked_transfer_decoder #(.SIZE_BITS(SizeBits)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o)
  );

  always #5 clk_i = ~clk_i;

  // Hex digit value, or 16 for anything else
  function automatic int hex_val(logic [7:0] b);
    if (b >= ctd_pkg::CharZero && b <= ctd_pkg::CharNine) return int'(b - ctd_pkg::CharZero);
    if (b >= ctd_pkg::CharLowA && b <= ctd_pkg::CharLowF) begin
      return int'(b - ctd_pkg::CharLowA) + 10;
    end
    if (b >= ctd_pkg::CharUpA && b <= ctd_pkg::CharUpF) return int'(b - ctd_pkg::CharUpA) + 10;
    return 16;
  endfunction

  function automatic void raise_error(ctd_pkg::kind_e k);
    dec_phase = ctd_pkg::PhError;
    expected_words.push_back('{out_byte: 8'h00, kind: k});
  endfunction

  // Advance the predictor by one accepted word, queueing any result
  function automatic void decode_byte(logic [7:0] b);
    int d;
    case (dec_phase)
      ctd_pkg::PhSize: begin
        d = hex_val(b);
        if (d < 16) begin
          if (digits >= MaxDigits) begin
            raise_error(ctd_pkg::KindBadSize);
          end else begin
            chunk_left = (chunk_left << 4) | 32'(d);
            digits     = digits + 4'd1;
          end
        end else if (b == ctd_pkg::CharCr) begin
          dec_phase = ctd_pkg::PhSizeCr;
        end else begin
          raise_error(ctd_pkg::KindBadSize);
        end
      end
      ctd_pkg::PhSizeCr: begin
        if (b != ctd_pkg::CharLf) begin
          raise_error(ctd_pkg::KindBadSize);
        end else begin
          digits = '0;
          if (chunk_left == 0) begin
            dec_phase = ctd_pkg::PhDone;
            expected_words.push_back('{out_byte: 8'h00, kind: ctd_pkg::KindDone});
          end else begin
            dec_phase = ctd_pkg::PhData;
          end
        end
      end
      ctd_pkg::PhData: begin
        chunk_left = chunk_left - 32'd1;
        if (chunk_left == 0) dec_phase = ctd_pkg::PhDataCr;
        expected_words.push_back('{out_byte: b, kind: ctd_pkg::KindPayload});
      end
      ctd_pkg::PhDataCr: begin
        if (b != ctd_pkg::CharCr) raise_error(ctd_pkg::KindNoCrLf);
        else dec_phase = ctd_pkg::PhDataLf;
      end
      ctd_pkg::PhDataLf: begin
        if (b != ctd_pkg::CharLf) begin
          raise_error(ctd_pkg::KindNoCrLf);
        end else begin
          dec_phase  = ctd_pkg::PhSize;
          chunk_left = '0;
          digits     = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Hex character for a digit, letters in random case
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return ctd_pkg::CharZero + 8'(v);
    return ($urandom_range(1) ? ctd_pkg::CharUpA : ctd_pkg::CharLowA) + 8'(v)
           - ctd_pkg::HexLetter;
  endfunction

  function automatic void push_crlf();
    body_q.push_back(ctd_pkg::CharCr);
    body_q.push_back(ctd_pkg::CharLf);
  endfunction

  // Size line of ndig digits, leading zeros as needed
  function automatic void push_size_line(logic [31:0] size, int ndig);
    for (int i = ndig - 1; i >= 0; i--) body_q.push_back(hex_char(size[4*i +: 4]));
    push_crlf();
  endfunction

  // Random byte that is not avoid (and not a hex digit if no_hex)
  function automatic logic [7:0] other_byte(logic [7:0] avoid, bit no_hex);
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == avoid || (no_hex && hex_val(b) < 16));
    return b;
  endfunction

  function automatic int sender_idle_pct(int n);
    return (n < 600) ? 19 : (n < 1200) ? 84 : 0;
  endfunction

  function automatic int receiver_idle_pct(int n);
    return (n < 600) ? 84 : (n < 1200) ? 19 : 0;
  endfunction

  // Sender: offer the next word, hold it until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    logic take;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'h00;
    end else begin
      take = in_valid_i && in_ready_o;
      if (take) begin
        decode_byte(data_byte_i);
        words_in <= words_in + 1;
      end
      if (!in_valid_i || take) begin
        if (body_q.size() != 0 && $urandom_range(99) >= sender_idle_pct(words_in)) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= body_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, result check
  always @(posedge clk_i or negedge rst_ni) begin
    dec_word_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word byte=%02h kind=%0d", $time, out_byte_o,
                   kind_o);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (kind_o !== 2'(want.kind)) begin
            $display("%0t: kind mismatch, expected %0d (%s) actual %0d", $time,
                     want.kind, want.kind.name(), kind_o);
            errors++;
          end
          if (out_byte_o !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h actual %02h", $time,
                     want.out_byte, out_byte_o);
            errors++;
          end
        end
      end
      if (!hold_done && words_in >= HoldAt) begin
        hold_done   <= 1'b1;
        hold_left   <= HoldLen;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct(words_in));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet <= 0;
      end else if (quiet >= QuietMax) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] sz;
    int          mind;
    // Directed: extreme payload bytes, CR/LF as payload, full-width size line
    push_size_line(32'd1, 1);
    body_q.push_back(8'hFF);
    push_crlf();
    push_size_line(32'd2, MaxDigits);
    body_q.push_back(8'h00);
    body_q.push_back(ctd_pkg::CharLf);
    push_crlf();
    push_size_line(32'd1, 1);
    body_q.push_back(ctd_pkg::CharCr);
    push_crlf();

    // Random well-formed chunks, mostly short
    while (body_q.size() < BodyWords) begin
      sz = ($urandom_range(19) == 0) ? $urandom_range(300, 64) : $urandom_range(40, 1);
      mind = 1;
      for (int k = 1; k < MaxDigits; k++) if ((sz >> (4 * k)) != 0) mind = k + 1;
      push_size_line(sz, $urandom_range(MaxDigits, mind));
      repeat (sz) body_q.push_back(8'($urandom_range(255)));
      push_crlf();
    end

    // One terminating case, since end and error states hold until reset
    case ($urandom_range(6))
      0: push_size_line(32'd0, $urandom_range(MaxDigits, 1));
      1: push_crlf();
      2: begin
        // one digit too many
        repeat (MaxDigits + 1) body_q.push_back(hex_char(4'($urandom_range(15))));
        push_crlf();
      end
      3: begin
        body_q.push_back(hex_char(4'($urandom_range(15))));
        body_q.push_back(other_byte(ctd_pkg::CharCr, 1'b1));
      end
      4: begin
        body_q.push_back(hex_char(4'($urandom_range(15, 1))));
        body_q.push_back(ctd_pkg::CharCr);
        body_q.push_back(other_byte(ctd_pkg::CharLf, 1'b0));
      end
      5: begin
        push_size_line(32'd2, 1);
        body_q.push_back(8'($urandom_range(255)));
        body_q.push_back(8'($urandom_range(255)));
        body_q.push_back(other_byte(ctd_pkg::CharCr, 1'b0));
      end
      default: begin
        push_size_line(32'd1, 1);
        body_q.push_back(8'($urandom_range(255)));
        body_q.push_back(ctd_pkg::CharCr);
        body_q.push_back(other_byte(ctd_pkg::CharLf, 1'b0));
      end
    endcase
    // Trailing words must be ignored, a size line and its payload among them
    push_size_line(32'd3, 1);
    repeat (3) body_q.push_back(8'($urandom_range(255)));
    repeat (6) body_q.push_back(8'($urandom_range(255)));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (body_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainLen) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
